FILE: rtl/lru_k_frame_replacer_unit_defines.svh
// ----------------------------------------------------------------------------
// LRU-K frame replacer: assertion macros
// Shared assertion wrappers, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_K_FRAME_REPLACER_UNIT_DEFINES_SVH
`define LRU_K_FRAME_REPLACER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LKFR_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) 1'b1 |-> (expr)) \
        else $error("lkfr: invariant violated");

`define LKFR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lkfr: implication violated");

`define LKFR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lkfr: next-cycle check violated");

`else

`define LKFR_ASSERT_ALWAYS(name, expr)
`define LKFR_ASSERT_IMP(name, ante, cons)
`define LKFR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/lkfr_pkg.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer package
// Sizes, field types, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package lkfr_pkg;

    localparam int FRAME_COUNT = 16;
    localparam int MAX_K      = 8;
    localparam int STAMP_BITS = 32;

    localparam int FRAME_BITS = 4;   // frame select field
    localparam int KREF_BITS  = 4;   // k_refs register
    localparam int FIU_BITS   = 5;   // frames_in_use register
    localparam int EVC_BITS   = 5;   // evictable_count field
    localparam int CFG_BITS   = 5;   // widest register

    localparam int SLOT_BITS  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CNT_BITS   = $clog2(MAX_K + 1);
    localparam int RAM_DEPTH  = FRAME_COUNT * MAX_K;
    localparam int ADDR_BITS  = $clog2(RAM_DEPTH);

    typedef enum logic [1:0] {
        MODE_ACCESS = 2'd0,
        MODE_MARK   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_EVICT  = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_K_REFS        = 1'b0,
        CFG_FRAMES_IN_USE = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_LAST,
        ST_EVICT,
        ST_RESULT
    } state_t;

    // ring slot of (head + offset), sum always below 2*MAX_K
    function automatic logic [SLOT_BITS-1:0] slot_wrap(input logic [CNT_BITS:0] sum);
        logic [CNT_BITS:0] res;
        res = sum;
        if (32'(sum) >= MAX_K) begin
            res = sum - (CNT_BITS+1)'(MAX_K);
        end
        return res[SLOT_BITS-1:0];
    endfunction

endpackage

FILE: rtl/lkfr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lkfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/lru_k_frame_replacer_unit.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer
// Records frame accesses and picks eviction victims by backward K-distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_* (valid/ready) carries one item: mode, frame select,
//   evictable. Result channel m_* (valid/ready) returns exactly one result
//   per item: victim_valid, victim_frame, evictable_count, error.
//   Config port: cfg_wr_en with cfg_index (0 k_refs, 1 frames_in_use) and
//   cfg_wdata; write only while the block is idle.
//   One item is in the block at a time; s_ready is high only when idle.
//   Access, mark and remove items pass through the EXEC and RESULT states;
//   RESULT loads the result into the output register and returns to idle.
//   Evict items pass through EXEC, SCAN over all FRAME_COUNT frames, LAST,
//   EVICT and RESULT; the candidate scan reads one frame's stamp per cycle
//   through a shared key comparator.
//   A finished result sits in the output register; while m_ready is low the
//   block holds the next result back and stays busy.
//   Reset (aresetn low, synchronous) clears all tracking, the stamp counter
//   and the evictable count; k_refs returns to 2 and frames_in_use to 16.
//   The stamp RAM is not cleared: only entries already written are read.
// ----------------------------------------------------------------------------
`include "lru_k_frame_replacer_unit_defines.svh"

module lru_k_frame_replacer_unit
    import lkfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [FRAME_BITS-1:0] s_frame_sel,
    input  logic                  s_evictable,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_victim_valid,
    output logic [FRAME_BITS-1:0] m_victim_frame,
    output logic [EVC_BITS-1:0]   m_evictable_count,
    output logic                  m_error
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;

    logic [KREF_BITS-1:0]    k_refs_reg, k_refs_next;
    logic [FIU_BITS-1:0]     fiu_reg, fiu_next;

    logic [FRAME_COUNT-1:0]  tracked_reg, tracked_next;
    logic [FRAME_COUNT-1:0]  mark_reg, mark_next;
    logic [CNT_BITS-1:0]     cnt_reg  [FRAME_COUNT];
    logic [CNT_BITS-1:0]     cnt_next [FRAME_COUNT];
    logic [SLOT_BITS-1:0]    head_reg  [FRAME_COUNT];
    logic [SLOT_BITS-1:0]    head_next [FRAME_COUNT];
    logic [STAMP_BITS-1:0]   time_reg, time_next;
    logic [EVC_BITS-1:0]     evc_reg, evc_next;

    mode_t                   mode_reg, mode_next;
    logic [FRAME_BITS-1:0]   fid_reg, fid_next;
    logic                    ev_reg, ev_next;

    logic [FRAME_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic                    p_valid_reg, p_valid_next;
    logic                    p_inf_reg, p_inf_next;
    logic                    p_zero_reg, p_zero_next;
    logic [FRAME_BITS-1:0]   p_frame_reg, p_frame_next;

    logic                    found_reg, found_next;
    logic                    best_inf_reg, best_inf_next;
    logic [STAMP_BITS-1:0]   best_key_reg, best_key_next;
    logic [FRAME_BITS-1:0]   best_frame_reg, best_frame_next;

    logic                    res_vv_reg, res_vv_next;
    logic [FRAME_BITS-1:0]   res_vf_reg, res_vf_next;
    logic                    res_err_reg, res_err_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_vv_reg, m_vv_next;
    logic [FRAME_BITS-1:0]   m_vf_reg, m_vf_next;
    logic [EVC_BITS-1:0]     m_evc_reg, m_evc_next;
    logic                    m_err_reg, m_err_next;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic                    in_accept;
    logic                    out_free;
    logic [CNT_BITS-1:0]     k_eff;

    logic                    sc_elig;
    logic                    sc_inf;
    logic                    sc_zero;
    logic [CNT_BITS-1:0]     sc_cnt;
    logic [CNT_BITS-1:0]     sc_off;
    logic [SLOT_BITS-1:0]    sc_slot;

    logic [STAMP_BITS-1:0]   cmp_key;
    logic                    cmp_take;

    logic                    ram_we;
    logic [ADDR_BITS-1:0]    ram_waddr;
    logic [ADDR_BITS-1:0]    ram_raddr;
    logic [STAMP_BITS-1:0]   ram_rdata;

    logic                    bad_id;
    logic                    cnt_over;

    lkfr_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_stamp_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (time_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (k_refs_reg == '0) begin
            k_eff = CNT_BITS'(1);
        end else if (32'(k_refs_reg) > MAX_K) begin
            k_eff = CNT_BITS'(MAX_K);
        end else begin
            k_eff = CNT_BITS'(k_refs_reg);
        end
    end

    // candidate of the frame under scan: ring slot of the key stamp
    always_comb begin
        sc_elig = tracked_reg[scan_idx_reg] && mark_reg[scan_idx_reg];
        sc_cnt  = cnt_reg[scan_idx_reg];
        sc_zero = (sc_cnt == '0);
        sc_inf  = (sc_cnt < k_eff);
        sc_off  = sc_inf ? '0 : (sc_cnt - k_eff);
        sc_slot = slot_wrap({1'b0, sc_off} + (CNT_BITS+1)'(head_reg[scan_idx_reg]));
        ram_raddr = ADDR_BITS'(scan_idx_reg) * ADDR_BITS'(MAX_K) + ADDR_BITS'(sc_slot);
    end

    // shared key comparator, one candidate per cycle
    always_comb begin
        cmp_key  = p_zero_reg ? '0 : ram_rdata;
        cmp_take = p_valid_reg &&
                   (!found_reg || (p_inf_reg && !best_inf_reg) ||
                    (p_inf_reg == best_inf_reg && cmp_key < best_key_reg));
    end

    assign bad_id = ({1'b0, fid_reg} >= fiu_reg);

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = (mode_reg == MODE_EVICT) ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN: begin
                if (32'(scan_idx_reg) == FRAME_COUNT - 1) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_EVICT;
            ST_EVICT: state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready           = (state_reg == ST_IDLE);
        m_valid           = m_valid_reg;
        m_victim_valid    = m_vv_reg;
        m_victim_frame    = m_vf_reg;
        m_evictable_count = m_evc_reg;
        m_error           = m_err_reg;
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        k_refs_next     = k_refs_reg;
        fiu_next        = fiu_reg;
        tracked_next    = tracked_reg;
        mark_next       = mark_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        time_next       = time_reg;
        evc_next        = evc_reg;
        mode_next       = mode_reg;
        fid_next        = fid_reg;
        ev_next         = ev_reg;
        scan_idx_next   = scan_idx_reg;
        p_valid_next    = 1'b0;
        p_inf_next      = p_inf_reg;
        p_zero_next     = p_zero_reg;
        p_frame_next    = p_frame_reg;
        found_next      = found_reg;
        best_inf_next   = best_inf_reg;
        best_key_next   = best_key_reg;
        best_frame_next = best_frame_reg;
        res_vv_next     = res_vv_reg;
        res_vf_next     = res_vf_reg;
        res_err_next    = res_err_reg;
        m_valid_next    = m_valid_reg;
        m_vv_next       = m_vv_reg;
        m_vf_next       = m_vf_reg;
        m_evc_next      = m_evc_reg;
        m_err_next      = m_err_reg;
        ram_we          = 1'b0;
        ram_waddr       = ADDR_BITS'(fid_reg) * ADDR_BITS'(MAX_K) + ADDR_BITS'(head_reg[fid_reg]);

        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_K_REFS:        k_refs_next = cfg_wdata[KREF_BITS-1:0];
                CFG_FRAMES_IN_USE: fiu_next    = cfg_wdata[FIU_BITS-1:0];
                default:           fiu_next    = fiu_reg;
            endcase
        end

        if (in_accept) begin
            mode_next = mode_t'(s_mode);
            fid_next  = s_frame_sel;
            ev_next   = s_evictable;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmp_take) begin
            found_next      = 1'b1;
            best_inf_next   = p_inf_reg;
            best_key_next   = cmp_key;
            best_frame_next = p_frame_reg;
        end

        unique case (state_reg)
            ST_EXEC: begin
                res_vv_next  = 1'b0;
                res_vf_next  = '0;
                res_err_next = 1'b0;
                if (mode_reg == MODE_EVICT) begin
                    found_next    = 1'b0;
                    scan_idx_next = '0;
                end else if (bad_id) begin
                    res_err_next = 1'b1;
                end else begin
                    unique case (mode_reg)
                        MODE_ACCESS: begin
                            ram_we = 1'b1;
                            if (time_reg != '1) begin
                                time_next = time_reg + 1'b1;
                            end
                            tracked_next[fid_reg] = 1'b1;
                            if (32'(cnt_reg[fid_reg]) < MAX_K) begin
                                ram_waddr = ADDR_BITS'(fid_reg) * ADDR_BITS'(MAX_K) +
                                            ADDR_BITS'(slot_wrap(
                                                {1'b0, cnt_reg[fid_reg]} +
                                                (CNT_BITS+1)'(head_reg[fid_reg])));
                                cnt_next[fid_reg] = cnt_reg[fid_reg] + 1'b1;
                            end else begin
                                // full ring: overwrite the oldest and move head on
                                head_next[fid_reg] = slot_wrap(
                                    (CNT_BITS+1)'(head_reg[fid_reg]) + 1'b1);
                            end
                        end
                        MODE_MARK: begin
                            if (tracked_reg[fid_reg]) begin
                                if (mark_reg[fid_reg] && !ev_reg && evc_reg != '0) begin
                                    evc_next = evc_reg - 1'b1;
                                end else if (!mark_reg[fid_reg] && ev_reg) begin
                                    evc_next = evc_reg + 1'b1;
                                end
                                mark_next[fid_reg] = ev_reg;
                            end
                        end
                        MODE_REMOVE: begin
                            if (tracked_reg[fid_reg]) begin
                                if (!mark_reg[fid_reg]) begin
                                    res_err_next = 1'b1;
                                end else begin
                                    if (evc_reg != '0) begin
                                        evc_next = evc_reg - 1'b1;
                                    end
                                    tracked_next[fid_reg] = 1'b0;
                                    mark_next[fid_reg]    = 1'b0;
                                    cnt_next[fid_reg]     = '0;
                                end
                            end
                        end
                        default: res_err_next = res_err_reg;
                    endcase
                end
            end
            ST_SCAN: begin
                p_valid_next  = sc_elig;
                p_inf_next    = sc_inf;
                p_zero_next   = sc_zero;
                p_frame_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            ST_EVICT: begin
                if (found_reg) begin
                    if (mark_reg[best_frame_reg] && evc_reg != '0) begin
                        evc_next = evc_reg - 1'b1;
                    end
                    tracked_next[best_frame_reg] = 1'b0;
                    mark_next[best_frame_reg]    = 1'b0;
                    cnt_next[best_frame_reg]     = '0;
                    res_vv_next = 1'b1;
                    res_vf_next = best_frame_reg;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_vv_next    = res_vv_reg;
                    m_vf_next    = res_vf_reg;
                    m_evc_next   = evc_reg;
                    m_err_next   = res_err_reg;
                end
            end
            default: begin
                scan_idx_next = scan_idx_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_refs_reg   <= KREF_BITS'(2);
            fiu_reg      <= FIU_BITS'(FRAME_COUNT);
            tracked_reg  <= '0;
            mark_reg     <= '0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
            time_reg     <= '0;
            evc_reg      <= '0;
            scan_idx_reg <= '0;
            p_valid_reg  <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_refs_reg   <= k_refs_next;
            fiu_reg      <= fiu_next;
            tracked_reg  <= tracked_next;
            mark_reg     <= mark_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            time_reg     <= time_next;
            evc_reg      <= evc_next;
            scan_idx_reg <= scan_idx_next;
            p_valid_reg  <= p_valid_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        fid_reg        <= fid_next;
        ev_reg         <= ev_next;
        p_inf_reg      <= p_inf_next;
        p_zero_reg     <= p_zero_next;
        p_frame_reg    <= p_frame_next;
        best_inf_reg   <= best_inf_next;
        best_key_reg   <= best_key_next;
        best_frame_reg <= best_frame_next;
        res_vv_reg     <= res_vv_next;
        res_vf_reg     <= res_vf_next;
        res_err_reg    <= res_err_next;
        m_vv_reg       <= m_vv_next;
        m_vf_reg       <= m_vf_next;
        m_evc_reg      <= m_evc_next;
        m_err_reg      <= m_err_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    always_comb begin
        cnt_over = 1'b0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (32'(cnt_reg[i]) > MAX_K) begin
                cnt_over = 1'b1;
            end
        end
    end

    `LKFR_ASSERT_ALWAYS(a_evc_matches_marks, 32'(evc_reg) == $countones(tracked_reg & mark_reg))
    `LKFR_ASSERT_ALWAYS(a_marks_tracked, ((mark_reg & ~tracked_reg) == '0) && !cnt_over)
    `LKFR_ASSERT_IMP(a_victim_is_candidate, (state_reg == ST_EVICT) && found_reg, tracked_reg[best_frame_reg] && mark_reg[best_frame_reg])
    `LKFR_ASSERT_IMP(a_victim_result_clean, m_valid_reg && m_vv_reg, !m_err_reg)
    `LKFR_ASSERT_NEXT(a_time_monotonic, 1'b1, time_reg >= $past(time_reg))

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// LRU-K frame replacer testbench
// Drives access, mark, remove and evict items through the valid/ready input,
// predicts each result with a behavioural copy of the replacement policy and
// checks every returned result, field by field, in order. Covers directed
// corner cases, register extremes, long output back-pressure and random
// traffic under several idling mixes.
// ----------------------------------------------------------------------------
module testbench;
    import lkfr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int CHUNK_ITEMS   = 52;

    typedef struct packed {
        logic                  victim_valid;
        logic [FRAME_BITS-1:0] victim_frame;
        logic [EVC_BITS-1:0]   evictable_count;
        logic                  error;
    } outcome_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic                  cfg_index;
    logic [CFG_BITS-1:0]   cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_mode;
    logic [FRAME_BITS-1:0] s_frame_sel;
    logic                  s_evictable;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_victim_valid;
    logic [FRAME_BITS-1:0] m_victim_frame;
    logic [EVC_BITS-1:0]   m_evictable_count;
    logic                  m_error;

    // behavioural copy of the replacer
    bit                    frame_tracked [FRAME_COUNT];
    bit                    frame_evictable [FRAME_COUNT];
    int                    hist_len [FRAME_COUNT];
    logic [STAMP_BITS-1:0] hist_stamp [FRAME_COUNT][MAX_K];
    logic [STAMP_BITS-1:0] stamp_clock;
    logic [EVC_BITS-1:0]   evictable_total;
    logic [KREF_BITS-1:0]  k_refs_reg;
    logic [FIU_BITS-1:0]   frames_in_use_reg;

    outcome_t outcome_q[$];
    outcome_t head_outcome;

    int mismatches  = 0;
    int cycle_count = 0;
    int snd_idle    = 0;
    int rcv_stall   = 0;
    int hold_total  = 0;
    int hold_count  = 0;

    lru_k_frame_replacer_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_frame_sel       (s_frame_sel),
        .s_evictable       (s_evictable),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_victim_valid    (m_victim_valid),
        .m_victim_frame    (m_victim_frame),
        .m_evictable_count (m_evictable_count),
        .m_error           (m_error)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_count < hold_total) begin
            m_ready = 1'b0;
            hold_count = hold_count + 1;
        end else begin
            m_ready = ($urandom_range(99) >= rcv_stall);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                head_outcome = outcome_q.pop_front();
                if (m_victim_valid !== head_outcome.victim_valid)
                    report_mismatch($sformatf("victim_valid got %0b want %0b",
                        m_victim_valid, head_outcome.victim_valid));
                if (m_victim_frame !== head_outcome.victim_frame)
                    report_mismatch($sformatf("victim_frame got %0d want %0d",
                        m_victim_frame, head_outcome.victim_frame));
                if (m_evictable_count !== head_outcome.evictable_count)
                    report_mismatch($sformatf("evictable_count got %0d want %0d",
                        m_evictable_count, head_outcome.evictable_count));
                if (m_error !== head_outcome.error)
                    report_mismatch($sformatf("error got %0b want %0b",
                        m_error, head_outcome.error));
            end
        end
    end

    function automatic void clear_replacer();
        for (int f = 0; f < FRAME_COUNT; f++) begin
            frame_tracked[f] = 1'b0;
            frame_evictable[f] = 1'b0;
            hist_len[f] = 0;
        end
        stamp_clock = '0;
        evictable_total = '0;
        k_refs_reg = KREF_BITS'(2);
        frames_in_use_reg = FIU_BITS'(16);
    endfunction

    function automatic void forget_frame(input int f);
        if (frame_evictable[f] && evictable_total > 0)
            evictable_total = evictable_total - 1'b1;
        frame_tracked[f] = 1'b0;
        frame_evictable[f] = 1'b0;
        hist_len[f] = 0;
    endfunction

    function automatic void push_stamp(input int f, input logic [STAMP_BITS-1:0] t);
        if (hist_len[f] < MAX_K) begin
            hist_stamp[f][hist_len[f]] = t;
            hist_len[f]++;
        end else begin
            for (int i = 0; i < MAX_K - 1; i++)
                hist_stamp[f][i] = hist_stamp[f][i+1];
            hist_stamp[f][MAX_K-1] = t;
        end
    endfunction

    // applies one item to the copy and returns the result it must produce
    function automatic outcome_t replace_step(input mode_t md, input logic [3:0] fid,
                                              input logic ev);
        outcome_t              res;
        int                    k_eff;
        int                    best;
        bit                    found;
        bit                    best_inf;
        bit                    inf;
        logic [STAMP_BITS-1:0] best_key;
        logic [STAMP_BITS-1:0] key;
        res = '0;
        k_eff = (k_refs_reg == 0) ? 1 : ((k_refs_reg > MAX_K) ? MAX_K : int'(k_refs_reg));
        if (md == MODE_EVICT) begin
            found = 1'b0;
            best_inf = 1'b0;
            best_key = '0;
            best = 0;
            // frames above a lowered frames_in_use still take part
            for (int f = 0; f < FRAME_COUNT; f++) begin
                if (frame_tracked[f] && frame_evictable[f]) begin
                    if (hist_len[f] == 0) begin
                        inf = 1'b1;
                        key = '0;
                    end else if (hist_len[f] < k_eff) begin
                        inf = 1'b1;
                        key = hist_stamp[f][0];
                    end else begin
                        inf = 1'b0;
                        key = hist_stamp[f][hist_len[f] - k_eff];
                    end
                    if (!found || (inf && !best_inf) || (inf == best_inf && key < best_key)) begin
                        found = 1'b1;
                        best_inf = inf;
                        best_key = key;
                        best = f;
                    end
                end
            end
            if (found) begin
                forget_frame(best);
                res.victim_valid = 1'b1;
                res.victim_frame = best[3:0];
            end
        end else if ({1'b0, fid} >= frames_in_use_reg) begin
            res.error = 1'b1;
        end else if (md == MODE_ACCESS) begin
            push_stamp(fid, stamp_clock);
            if (stamp_clock != '1)
                stamp_clock = stamp_clock + 1'b1;
            frame_tracked[fid] = 1'b1;
        end else if (md == MODE_MARK) begin
            if (frame_tracked[fid]) begin
                if (frame_evictable[fid] && !ev && evictable_total > 0)
                    evictable_total = evictable_total - 1'b1;
                else if (!frame_evictable[fid] && ev)
                    evictable_total = evictable_total + 1'b1;
                frame_evictable[fid] = ev;
            end
        end else begin
            if (frame_tracked[fid]) begin
                if (!frame_evictable[fid])
                    res.error = 1'b1;
                else
                    forget_frame(fid);
            end
        end
        res.evictable_count = evictable_total;
        return res;
    endfunction

    task automatic send_item(input mode_t md, input logic [3:0] fid, input logic ev);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode = md;
        s_frame_sel = fid;
        s_evictable = ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        outcome_q.push_back(replace_step(md, fid, ev));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] val);
        @(negedge aclk);
        s_valid = 1'b0;
        while (outcome_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_K_REFS)
            k_refs_reg = val[KREF_BITS-1:0];
        else
            frames_in_use_reg = val[FIU_BITS-1:0];
    endtask

    // mostly well-formed traffic on valid ids, with a share of stray ids
    task automatic send_random_item();
        mode_t      md;
        logic [3:0] fid;
        logic       ev;
        int         r;
        r = $urandom_range(99);
        if (r < 40)
            md = MODE_ACCESS;
        else if (r < 65)
            md = MODE_MARK;
        else if (r < 77)
            md = MODE_REMOVE;
        else
            md = MODE_EVICT;
        if (frames_in_use_reg != 0 && $urandom_range(99) < 92) begin
            if (frames_in_use_reg > FRAME_COUNT)
                fid = 4'($urandom_range(FRAME_COUNT - 1));
            else
                fid = 4'($urandom_range(int'(frames_in_use_reg) - 1));
        end else begin
            fid = 4'($urandom_range(15));
        end
        ev = ($urandom_range(99) < 75);
        send_item(md, fid, ev);
    endtask

    task automatic test_basic_ops();
        send_item(MODE_EVICT, 4'd0, 1'b0);      // nothing to evict
        send_item(MODE_ACCESS, 4'd0, 1'b0);
        send_item(MODE_ACCESS, 4'd15, 1'b0);
        send_item(MODE_ACCESS, 4'd0, 1'b1);
        send_item(MODE_MARK, 4'd15, 1'b1);
        send_item(MODE_MARK, 4'd0, 1'b1);
        send_item(MODE_MARK, 4'd3, 1'b1);       // untracked frame
        send_item(MODE_REMOVE, 4'd5, 1'b0);     // untracked frame
        send_item(MODE_ACCESS, 4'd7, 1'b0);
        send_item(MODE_REMOVE, 4'd7, 1'b0);     // pinned frame
        send_item(MODE_EVICT, 4'd9, 1'b1);      // fewer than K accesses goes first
        send_item(MODE_MARK, 4'd7, 1'b1);
        send_item(MODE_MARK, 4'd7, 1'b0);
        send_item(MODE_MARK, 4'd7, 1'b1);
        send_item(MODE_ACCESS, 4'd7, 1'b0);
        send_item(MODE_EVICT, 4'd0, 1'b0);
        send_item(MODE_REMOVE, 4'd7, 1'b0);
    endtask

    task automatic test_id_range();
        send_item(MODE_ACCESS, 4'd12, 1'b0);
        send_item(MODE_MARK, 4'd12, 1'b1);
        write_reg(CFG_FRAMES_IN_USE, 5'd4);
        send_item(MODE_ACCESS, 4'd9, 1'b0);
        send_item(MODE_MARK, 4'd9, 1'b1);
        send_item(MODE_REMOVE, 4'd9, 1'b0);
        send_item(MODE_ACCESS, 4'd2, 1'b0);
        send_item(MODE_MARK, 4'd2, 1'b1);
        send_item(MODE_EVICT, 4'd0, 1'b0);      // frame 12 still a candidate
        send_item(MODE_EVICT, 4'd0, 1'b0);
        write_reg(CFG_FRAMES_IN_USE, 5'd0);
        send_item(MODE_ACCESS, 4'd0, 1'b0);
        send_item(MODE_EVICT, 4'd0, 1'b0);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_K_REFS, 5'd4);
        write_reg(CFG_FRAMES_IN_USE, 5'd16);
        hold_total = 300;
        repeat (24) send_random_item();
    endtask

    task automatic test_random_traffic();
        int          sidle [4];
        int          rstall [4];
        logic [4:0]  kval [6];
        logic [4:0]  fval [6];
        sidle = '{0, 53, 0, 8};
        rstall = '{0, 0, 53, 8};
        // bit 4 of a k_refs write is dropped by the 4-bit register
        kval = '{5'd2, 5'd1, 5'd8, 5'd0, 5'd15, 5'd19};
        fval = '{5'd16, 5'd16, 5'd12, 5'd8, 5'd31, 5'd1};
        for (int p = 0; p < 4; p++) begin
            snd_idle = sidle[p];
            rcv_stall = rstall[p];
            for (int c = 0; c < 6; c++) begin
                write_reg(CFG_K_REFS, kval[(c + p) % 6]);
                write_reg(CFG_FRAMES_IN_USE, fval[c]);
                repeat (CHUNK_ITEMS) send_random_item();
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_K_REFS;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mode = MODE_ACCESS;
        s_frame_sel = '0;
        s_evictable = 1'b0;
        clear_replacer();
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_basic_ops();
        test_id_range();
        snd_idle = 20;
        rcv_stall = 20;
        test_backpressure();
        test_random_traffic();

        @(negedge aclk);
        s_valid = 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
